/* rtl/modexp_pkg.sv */
package modexp_pkg;

  localparam int DATA_WIDTH = 32;

  localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = 32'd91;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL_ACC,
    ST_SQUARE,
    ST_DONE
  } state_t;

endpackage

/* rtl/modular_exponentiation.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------
// input    | start, busy          | in_base_value, in_exponent
// result   | out_valid (strobe)   | out_power_result
// config   | cfg_we               | cfg_wdata (modulus)
//
// An item is taken when start is high and busy is low; busy stays high until its
// result is strobed. All modular products run on one bit-serial multiplier: one
// reduces the base, and each exponent bit up to the top set bit adds a check state,
// a product when set and a squaring below the top bit, before the result is
// strobed from ST_DONE. Reset is synchronous and restores the modulus to 91;
// no stalls.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [modexp_pkg::DATA_WIDTH-1:0]   in_base_value,
  input  logic [modexp_pkg::DATA_WIDTH-1:0]   in_exponent,
  output logic                                out_valid,
  output logic [modexp_pkg::DATA_WIDTH-1:0]   out_power_result,
  input  logic                                cfg_we,
  input  logic [modexp_pkg::DATA_WIDTH-1:0]   cfg_wdata
);

  localparam int W = OPERAND_WIDTH;

  modexp_pkg::state_t state_r, state_nxt;

  logic [W-1:0] mod_r;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic [W-1:0] e_r, e_nxt;
  logic         go_r, go_nxt;

  logic [W:0]   mod_eff;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done;
  logic [W-1:0] mul_product;
  logic         e_rest_zero;

  // A zero modulus behaves as 2^W, so the reductions wrap.
  assign mod_eff     = (mod_r == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_r};
  assign e_rest_zero = (e_r[W-1:1] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= modexp_pkg::MODULUS_RESET[W-1:0];
    end else if (cfg_we) begin
      mod_r <= cfg_wdata[W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      modexp_pkg::ST_IDLE: begin
        if (start) state_nxt = modexp_pkg::ST_REDUCE;
      end
      modexp_pkg::ST_REDUCE: begin
        if (mul_done) state_nxt = modexp_pkg::ST_CHECK;
      end
      modexp_pkg::ST_CHECK: begin
        if (e_r == '0) begin
          state_nxt = modexp_pkg::ST_DONE;
        end else if (e_r[0]) begin
          state_nxt = modexp_pkg::ST_MUL_ACC;
        end else begin
          state_nxt = modexp_pkg::ST_SQUARE;
        end
      end
      modexp_pkg::ST_MUL_ACC: begin
        if (mul_done) begin
          state_nxt = e_rest_zero ? modexp_pkg::ST_DONE : modexp_pkg::ST_SQUARE;
        end
      end
      modexp_pkg::ST_SQUARE: begin
        if (mul_done) state_nxt = modexp_pkg::ST_CHECK;
      end
      modexp_pkg::ST_DONE: begin
        state_nxt = modexp_pkg::ST_IDLE;
      end
      default: state_nxt = modexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    b_nxt   = b_r;
    e_nxt   = e_r;
    go_nxt  = (state_nxt != state_r) &&
              (state_nxt inside {modexp_pkg::ST_REDUCE, modexp_pkg::ST_MUL_ACC,
                                 modexp_pkg::ST_SQUARE});
    mul_a   = b_r;
    mul_b   = b_r;
    case (state_r)
      modexp_pkg::ST_IDLE: begin
        if (start) begin
          b_nxt   = in_base_value[W-1:0];
          e_nxt   = in_exponent[W-1:0];
          acc_nxt = W'(1);
        end
      end
      modexp_pkg::ST_REDUCE: begin
        mul_b = (mod_r == W'(1)) ? '0 : W'(1);
        if (mul_done) b_nxt = mul_product;
      end
      modexp_pkg::ST_MUL_ACC: begin
        mul_a = acc_r;
        if (mul_done) acc_nxt = mul_product;
      end
      modexp_pkg::ST_SQUARE: begin
        if (mul_done) begin
          b_nxt = mul_product;
          e_nxt = {1'b0, e_r[W-1:1]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= modexp_pkg::ST_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    e_r   <= e_nxt;
  end

  modexp_mul #(
    .OPERAND_WIDTH(W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go_r),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mod_eff (mod_eff),
    .done    (mul_done),
    .product (mul_product)
  );

  assign busy             = (state_r != modexp_pkg::ST_IDLE);
  assign out_valid        = (state_r == modexp_pkg::ST_DONE);
  assign out_power_result = modexp_pkg::DATA_WIDTH'(acc_r);

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after result");

  a_product_range: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> ({1'b0, mul_product} < mod_eff))
    else $error("modular product not reduced");
`endif

endmodule

/* rtl/modexp_mul.sv */
// Bit-serial interleaved modular multiplier. The multiplier operand is shifted
// in most significant bit first; the multiplicand and modulus must stay stable
// until done, and the multiplicand must be below the modulus.
module modexp_mul #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [OPERAND_WIDTH-1:0] mul_a,
  input  logic [OPERAND_WIDTH-1:0] mul_b,
  input  logic [OPERAND_WIDTH:0]   mod_eff,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] product
);

  localparam int W    = OPERAND_WIDTH;
  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    a_sr_r, a_sr_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;

  logic [W:0] dbl;
  logic [W:0] dbl_red;
  logic [W:0] sum;
  logic [W:0] sum_red;

  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= mod_eff) ? (dbl - mod_eff) : dbl;
    sum     = dbl_red + (a_sr_r[W-1] ? {1'b0, mul_b} : '0);
    sum_red = (sum >= mod_eff) ? (sum - mod_eff) : sum;
  end

  always_comb begin
    a_sr_nxt = a_sr_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      a_sr_nxt = mul_a;
      acc_nxt  = '0;
      cnt_nxt  = CntW'(W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      a_sr_nxt = {a_sr_r[W-2:0], 1'b0};
      acc_nxt  = sum_red[W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_sr_r <= a_sr_nxt;
    acc_r  <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule
